/* hw/rtl/rpi_pkg.sv */
// ---------------------------------------------------------------------------
// rpi_pkg: shared types and constants for the ray/plane intersection pipeline
// Payload structs, register indexes, status codes and divider sizing.
// ---------------------------------------------------------------------------
`default_nettype none
package rpi_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_ZERO = 3'd4;

    typedef enum logic [1:0] {
        ST_HIT = 2'd0,
        ST_ON_PLANE = 2'd1,
        ST_PARALLEL = 2'd2,
        ST_BEHIND = 2'd3
    } status_t;

    localparam logic signed [31:0] NO_HIT = -32'sd65536;

    // dividend |toPlane| << 16 fits in 48 bits; quotient kept to 48 bits
    localparam int DIV_W = 48;
    localparam int DIV_STEPS_DEFAULT = 4;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic signed [31:0] hit_distance;
        logic [1:0]         hit_status;
    } hit_t;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] plane_offset;
        logic [15:0]        near_zero_limit;
    } plane_t;

    // decision handed from the dot stage to the divider
    typedef struct packed {
        logic         bypass;
        logic [1:0]   status;
        logic         neg;
        logic [31:0]  num_mag;
        logic [31:0]  den_mag;
    } div_job_t;

    // v saturated to signed 32
    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        if (v > 80'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -80'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/ray_plane_intersect.sv */
// ---------------------------------------------------------------------------
// ray_plane_intersect: distance along a ray to a configured plane
// Fixed-point dot products, classification and pipelined division.
// ---------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------
//  ray in   | start & !busy            | ray (rpi_pkg::ray_t)
//  hit out  | done, one cycle          | hit (rpi_pkg::hit_t)
//  config   | cfg_we                   | cfg_index, cfg_data
//
// One ray per cycle. The pipeline has five multiply/sum/classify stages,
// one divider stage per DIV_STEPS quotient bits and one output register.
// busy is held low; the receiver cannot stall and every transfer on done
// is final. Reset loads the default plane (normal +z, offset 0, threshold
// 1) and empties the pipeline.
`default_nettype none
module ray_plane_intersect #(
    parameter int DIV_STEPS = rpi_pkg::DIV_STEPS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire rpi_pkg::ray_t                 ray,
    output logic                               done,
    output rpi_pkg::hit_t                      hit,
    input  wire logic                          cfg_we,
    input  wire logic [rpi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rpi_pkg::CFG_DATA_W-1:0] cfg_data
);
    rpi_pkg::plane_t plane_reg;
    rpi_pkg::div_job_t job;
    logic job_valid;

    // config writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.normal_x <= '0;
            plane_reg.normal_y <= '0;
            plane_reg.normal_z <= 32'sh40000000;
            plane_reg.plane_offset <= '0;
            plane_reg.near_zero_limit <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rpi_pkg::REG_NORMAL_X:     plane_reg.normal_x <= cfg_data;
                rpi_pkg::REG_NORMAL_Y:     plane_reg.normal_y <= cfg_data;
                rpi_pkg::REG_NORMAL_Z:     plane_reg.normal_z <= cfg_data;
                rpi_pkg::REG_PLANE_OFFSET: plane_reg.plane_offset <= cfg_data;
                rpi_pkg::REG_NEAR_ZERO:    plane_reg.near_zero_limit <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // fully pipelined: always ready
    assign busy = 1'b0;

    rpi_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .ray       (ray),
        .plane     (plane_reg),
        .out_valid (job_valid),
        .job       (job)
    );

    rpi_div #(.STEPS(DIV_STEPS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (job_valid),
        .job       (job),
        .out_valid (done),
        .result    (hit)
    );
endmodule
`default_nettype wire

/* hw/rtl/rpi_dot.sv */
// ---------------------------------------------------------------------------
// rpi_dot: multiply/accumulate front end
// Forms toPlane and along over five register stages and classifies the ray.
// ---------------------------------------------------------------------------
`default_nettype none
module rpi_dot (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire rpi_pkg::ray_t     ray,
    input  wire rpi_pkg::plane_t   plane,
    output logic                   out_valid,
    output rpi_pkg::div_job_t      job
);
    // stage 1: per-axis difference n*d - o*2^30 (64 bit) and direction copy
    logic [4:0] vld_reg;
    logic signed [63:0] diff_reg [3];
    logic signed [31:0] dir_reg [3];
    logic signed [31:0] nrm_reg [3];
    // stage 2: 32x32 partial products (upper and lower half of the difference) and dir*n
    logic signed [63:0] tp_hi_reg [3];
    logic signed [64:0] tp_lo_reg [3];
    logic signed [63:0] al_reg [3];
    // stage 3: per-axis toPlane terms, rescaled along
    logic signed [95:0] tp_reg [3];
    logic signed [31:0] along_pre_reg;
    // stage 4: rescaled sums
    logic signed [31:0] to_plane_reg, along_reg;
    // stage 5: job
    rpi_pkg::div_job_t job_reg;

    logic signed [31:0] nrm_in [3];
    logic signed [31:0] org_in [3];
    logic signed [31:0] dir_in [3];
    logic signed [97:0] tp_sum;
    logic signed [65:0] al_sum;
    rpi_pkg::div_job_t job_next;
    logic [31:0] tp_mag, al_mag;

    assign nrm_in = '{plane.normal_x, plane.normal_y, plane.normal_z};
    assign org_in = '{ray.origin_x, ray.origin_y, ray.origin_z};
    assign dir_in = '{ray.dir_x, ray.dir_y, ray.dir_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_reg[i] <= 64'(nrm_in[i] * plane.plane_offset)
                         - {{2{org_in[i][31]}}, org_in[i], 30'd0};
            dir_reg[i] <= dir_in[i];
            nrm_reg[i] <= nrm_in[i];
            tp_hi_reg[i] <= 64'($signed(diff_reg[i][63:32]) * nrm_reg[i]);
            tp_lo_reg[i] <= 65'($signed({1'b0, diff_reg[i][31:0]}) * nrm_reg[i]);
            al_reg[i] <= 64'(dir_reg[i] * nrm_reg[i]);
            tp_reg[i] <= (96'(tp_hi_reg[i]) <<< 32) + 96'(tp_lo_reg[i]);
        end
        along_pre_reg <= rpi_pkg::sat32(80'(al_sum >>> 30));
        to_plane_reg <= rpi_pkg::sat32(80'(tp_sum >>> 60));
        along_reg <= along_pre_reg;
        job_reg <= job_next;
    end

    always_comb
    begin
        tp_sum = 98'(tp_reg[0]) + 98'(tp_reg[1]) + 98'(tp_reg[2]);
        al_sum = 66'(al_reg[0]) + 66'(al_reg[1]) + 66'(al_reg[2]);
        tp_mag = to_plane_reg[31] ? 32'(-to_plane_reg) : to_plane_reg;
        al_mag = along_reg[31] ? 32'(-along_reg) : along_reg;
        job_next.num_mag = tp_mag;
        job_next.den_mag = al_mag;
        job_next.neg = to_plane_reg[31] ^ along_reg[31];
        job_next.bypass = 1'b1;
        job_next.status = rpi_pkg::ST_HIT;
        priority if (tp_mag < 32'(plane.near_zero_limit))
            job_next.status = rpi_pkg::ST_ON_PLANE;
        else if (along_reg == 32'sd0 || al_mag < 32'(plane.near_zero_limit))
            job_next.status = rpi_pkg::ST_PARALLEL;
        else if (to_plane_reg != 32'sd0 && job_next.neg)
            job_next.status = rpi_pkg::ST_BEHIND;
        else
            job_next.bypass = 1'b0;
    end

    assign out_valid = vld_reg[4];
    assign job = job_reg;
endmodule
`default_nettype wire

/* hw/rtl/rpi_div.sv */
// ---------------------------------------------------------------------------
// rpi_div: pipelined restoring divider
// Unsigned (num << 16) / den, STEPS quotient bits per stage, then saturate.
// ---------------------------------------------------------------------------
`default_nettype none
module rpi_div #(
    parameter int STEPS = rpi_pkg::DIV_STEPS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire rpi_pkg::div_job_t job,
    output logic                   out_valid,
    output rpi_pkg::hit_t          result
);
    localparam int W = rpi_pkg::DIV_W;
    localparam int STAGES = (W + STEPS - 1) / STEPS;
    localparam int TOT = STAGES * STEPS;

    // entry s holds the state after stage s
    logic [STAGES-1:0] vld_reg;
    logic [TOT-1:0] num_reg [STAGES];   // shifts out dividend, in quotient
    logic [32:0] rem_reg [STAGES];
    logic [31:0] den_reg [STAGES];
    logic bypass_reg [STAGES];
    logic [1:0] status_reg [STAGES];
    rpi_pkg::hit_t result_reg;
    rpi_pkg::hit_t result_next;
    logic out_vld_reg;

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic v_in;
        logic [TOT-1:0] n_in;
        logic [32:0] r_in;
        logic [31:0] d_in;
        logic b_in;
        logic [1:0] st_in;
        logic [TOT-1:0] n_next;
        logic [32:0] r_next;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign n_in = TOT'({job.num_mag, 16'd0});
            assign r_in = '0;
            assign d_in = job.den_mag;
            assign b_in = job.bypass;
            assign st_in = job.status;
        end
        else
        begin : g_next
            assign v_in = vld_reg[s-1];
            assign n_in = num_reg[s-1];
            assign r_in = rem_reg[s-1];
            assign d_in = den_reg[s-1];
            assign b_in = bypass_reg[s-1];
            assign st_in = status_reg[s-1];
        end

        always_comb
        begin
            n_next = n_in;
            r_next = r_in;
            for (int b = 0; b < STEPS; b++)
            begin
                r_next = {r_next[31:0], n_next[TOT-1]};
                n_next = {n_next[TOT-2:0], 1'b0};
                if (r_next >= {1'b0, d_in})
                begin
                    r_next = r_next - {1'b0, d_in};
                    n_next[0] = 1'b1;
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= v_in;
        end
        always_ff @(posedge clk)
        begin
            num_reg[s] <= n_next;
            rem_reg[s] <= r_next;
            den_reg[s] <= d_in;
            bypass_reg[s] <= b_in;
            status_reg[s] <= st_in;
        end
    end

    always_comb
    begin
        result_next.hit_status = status_reg[STAGES-1];
        if (bypass_reg[STAGES-1])
            result_next.hit_distance = (status_reg[STAGES-1] == rpi_pkg::ST_ON_PLANE)
                                     ? 32'sd0 : rpi_pkg::NO_HIT;
        else if (num_reg[STAGES-1] > TOT'(32'h7fffffff))
            result_next.hit_distance = 32'sh7fffffff;
        else
            result_next.hit_distance = num_reg[STAGES-1][31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= vld_reg[STAGES-1];
    end

    always_ff @(posedge clk)
        result_reg <= result_next;

    assign out_valid = out_vld_reg;
    assign result = result_reg;
endmodule
`default_nettype wire

/* hw/rtl/rpi_checker.sv */
// ---------------------------------------------------------------------------
// rpi_checker: port-level checks for ray_plane_intersect
// Status/distance consistency, reset behavior and that start is never refused.
// ---------------------------------------------------------------------------
`default_nettype none
module rpi_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          done,
    input wire rpi_pkg::hit_t hit
);
    a_on_plane_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit.hit_status == rpi_pkg::ST_ON_PLANE |-> hit.hit_distance == 32'sd0)
        else $error("on-plane result with nonzero distance");

    a_miss_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
        done && (hit.hit_status == rpi_pkg::ST_PARALLEL
              || hit.hit_status == rpi_pkg::ST_BEHIND)
        |-> hit.hit_distance == rpi_pkg::NO_HIT)
        else $error("miss result without -1.0");

    a_hit_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit.hit_status == rpi_pkg::ST_HIT |-> !hit.hit_distance[31])
        else $error("hit with negative distance");

    a_no_done_after_reset: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("done right after reset");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("ray refused");
endmodule

bind ray_plane_intersect rpi_checker u_rpi_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .hit   (hit)
);
`default_nettype wire

/* bench/hit_checker.sv */
// ---------------------------------------------------------------------------
// hit_checker: prediction and comparison for the ray/plane intersection block
// Tracks plane register writes, predicts one hit per accepted ray, and checks
// each done strobe against the oldest pending prediction.
// ---------------------------------------------------------------------------
`default_nettype none
module hit_checker
    import rpi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire ray_t                  ray,
    input  wire logic                  done,
    input  wire hit_t                  hit,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         errors,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    longint nrm_x, nrm_y, nrm_z, offset, limit;
    hit_t   hit_queue[$];

    function automatic logic signed [127:0] axis_product(longint n, longint o);
        longint                diff;
        logic signed [127:0]   a;
        logic signed [127:0]   b;
        diff = n * offset - o * 64'sd1073741824;
        a = diff;
        b = n;
        return a * b;
    endfunction

    function automatic longint clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 64'sd2147483647;
        else if (v < -128'sd2147483648)
            return -64'sd2147483648;
        else
            return longint'(v);
    endfunction

    function automatic hit_t predict_hit(ray_t r);
        logic signed [127:0] acc;
        logic signed [127:0] p0;
        logic signed [127:0] p1;
        logic signed [127:0] p2;
        longint              to_plane;
        longint              along;
        longint              quot;
        longint              vx, vy, vz;
        hit_t                h;
        acc = axis_product(nrm_z, r.origin_z) + axis_product(nrm_y, r.origin_y)
            + axis_product(nrm_x, r.origin_x);
        to_plane = clamp32(acc >>> 60);
        vx = r.dir_x;
        vy = r.dir_y;
        vz = r.dir_z;
        p0 = vz * nrm_z;
        p1 = vy * nrm_y;
        p2 = vx * nrm_x;
        along = clamp32((p0 + p1 + p2) >>> 30);
        if ((to_plane < 0 ? -to_plane : to_plane) < limit)
        begin
            h.hit_distance = 32'sd0;
            h.hit_status = ST_ON_PLANE;
        end
        else if (along == 0 || (along < 0 ? -along : along) < limit)
        begin
            h.hit_distance = NO_HIT;
            h.hit_status = ST_PARALLEL;
        end
        else if (to_plane != 0 && ((to_plane < 0) != (along < 0)))
        begin
            h.hit_distance = NO_HIT;
            h.hit_status = ST_BEHIND;
        end
        else
        begin
            quot = (to_plane * 64'sd65536) / along;
            if (quot > 64'sd2147483647)
                quot = 64'sd2147483647;
            h.hit_distance = quot[31:0];
            h.hit_status = ST_HIT;
        end
        return h;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    assign pending = hit_queue.size();

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        hit_t want;
        if (!rst_n)
        begin
            nrm_x = 0;
            nrm_y = 0;
            nrm_z = 64'sd1073741824;
            offset = 0;
            limit = 1;
            hit_queue.delete();
        end
        else
        begin
            // check the returning hit before queuing this edge's ray
            if (done)
            begin
                if (hit_queue.size() == 0)
                    report_mismatch("unexpected done", 1, 0);
                else
                begin
                    want = hit_queue.pop_front();
                    if (hit.hit_distance !== want.hit_distance)
                        report_mismatch("hit_distance", hit.hit_distance, want.hit_distance);
                    if (hit.hit_status !== want.hit_status)
                        report_mismatch("hit_status", hit.hit_status, want.hit_status);
                end
            end
            if (start && !busy)
                hit_queue.push_back(predict_hit(ray));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NORMAL_X:     nrm_x = longint'($signed(cfg_data));
                    REG_NORMAL_Y:     nrm_y = longint'($signed(cfg_data));
                    REG_NORMAL_Z:     nrm_z = longint'($signed(cfg_data));
                    REG_PLANE_OFFSET: offset = longint'($signed(cfg_data));
                    REG_NEAR_ZERO:    limit = cfg_data[15:0];
                    default:          ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

/* bench/ray_plane_intersect_tb.sv */
// ---------------------------------------------------------------------------
// ray_plane_intersect_tb: stimulus and verdict for the ray/plane block
// Steps through several plane settings, sends directed and random rays with
// random gaps, and leaves all checking to hit_checker.
// ---------------------------------------------------------------------------
`default_nettype none
module ray_plane_intersect_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rpi_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;   // a little over twice the pipeline depth

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    ray_t                  ray;
    logic                  done;
    hit_t                  hit;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    cycles;

    ray_plane_intersect dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .ray       (ray),
        .done      (done),
        .hit       (hit),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hit_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .ray       (ray),
        .done      (done),
        .hit       (hit),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stop a hung run
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Pick a gap: mostly back to back, sometimes short, rarely long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 40);
    endfunction

    // Draw one coordinate: moderate values most often so hits happen, plus
    // full-range noise, the extremes and zero.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2:    return $urandom();
            3:          return 32'h7fffffff;
            4:          return 32'h80000000;
            5:          return 32'd0;
            default:    return 32'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
        endcase
    endfunction

    function automatic ray_t pick_ray();
        ray_t r;
        r.origin_x = pick_coord();
        r.origin_y = pick_coord();
        r.origin_z = pick_coord();
        r.dir_x = pick_coord();
        r.dir_y = pick_coord();
        r.dir_z = pick_coord();
        return r;
    endfunction

    function automatic ray_t make_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                      logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        ray_t r;
        r.origin_x = ox;
        r.origin_y = oy;
        r.origin_z = oz;
        r.dir_x = dx;
        r.dir_y = dy;
        r.dir_z = dz;
        return r;
    endfunction

    // Present one ray, hold it until the transfer, then idle for the given gap.
    // start stays high across back-to-back transfers.
    task automatic send_ray(ray_t r, int gap);
        @(negedge clk);
        start <= 1'b1;
        ray <= r;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Hold off until every predicted hit has come back, then let the
    // pipeline settle.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Drain first so plane registers only change while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                             logic [31:0] off, logic [31:0] lim);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_PLANE_OFFSET, off);
        write_reg(REG_NEAR_ZERO, lim);
    endtask

    task automatic random_rays(int count);
        for (int i = 0; i < count; i++)
        begin
            send_ray(pick_ray(), pick_gap());
            // one mid-stream pause until everything has come back
            if (i == count / 2)
                drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        ray = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rays against the reset plane z = 0.
        send_ray(make_ray(0, 0, 0, 0, 0, 32'h10000), 0);                 // origin on plane
        send_ray(make_ray(0, 0, 32'h10000, 32'h10000, 0, 0), 0);        // parallel
        send_ray(make_ray(0, 0, 32'h10000, 0, 0, 32'h10000), 1);        // plane behind
        send_ray(make_ray(0, 0, 32'hffff0000, 0, 0, 32'h10000), 0);     // hit at 1.0
        send_ray(make_ray(0, 0, 32'hffff0000, 0, 0, 32'h20000), 0);     // hit at 0.5
        send_ray(make_ray(0, 0, 32'h80000001, 0, 0, 32'd1), 2);         // quotient saturates
        send_ray(make_ray(0, 0, 32'hffffffff, 0, 0, 32'h7fffffff), 0);  // tiny quotient
        send_ray(make_ray(0, 0, 32'd1, 0, 0, 32'hffffffff), 0);         // hit at 1.0
        send_ray(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0);
        send_ray(make_ray(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'h80000000), 0);
        send_ray(make_ray(32'h80000000, 0, 32'h80000000, 0, 0, 32'h80000000), 0);
        send_ray(make_ray(0, 0, 32'hfff00000, 32'h7fffffff, 0, 32'h10000), 3);
        random_rays(200);

        // Plane z = 10 with a wider zero band.
        set_plane(0, 0, 32'h40000000, 32'h000a0000, 32'h100);
        send_ray(make_ray(0, 0, 32'h000a0000, 0, 0, 32'h10000), 0);     // on plane
        send_ray(make_ray(0, 0, 0, 0, 0, 32'h80), 0);                   // within band: parallel
        send_ray(make_ray(0, 0, 0, 0, 0, 32'h10000), 0);                // hit at 10.0
        random_rays(200);

        // Plane x = 5 facing -x.
        set_plane(32'hc0000000, 0, 0, 32'hfffb0000, 32'd1);
        random_rays(200);

        // Diagonal normal in x/y, a few bad indexes that must be ignored.
        set_plane(32'd759250125, 32'd759250125, 0, 32'hffe00000, 32'd16);
        write_reg(3'd5, $urandom());
        write_reg(3'd6, $urandom());
        write_reg(3'd7, $urandom());
        random_rays(200);

        // Zero band off: exact zeros fall to the parallel rule.
        set_plane(0, 32'h40000000, 0, 0, 32'd0);
        send_ray(make_ray(0, 0, 0, 32'h10000, 0, 32'h10000), 0);        // toPlane 0, along 0
        send_ray(make_ray(0, 32'h10000, 0, 32'h10000, 0, 0), 0);        // along 0
        send_ray(make_ray(0, 32'hffff0000, 0, 0, 32'h10000, 0), 0);     // hit
        random_rays(200);

        // Extremes of every register.
        set_plane(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'hffff);
        random_rays(100);
        set_plane(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'hffff0000);
        random_rays(100);

        // Fully random planes.
        for (int p = 0; p < 2; p++)
        begin
            set_plane($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            random_rays(100);
        end

        drain();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
